@@ hdl/fpa_pkg.sv @@
// fpa_pkg: shared types, constants and op codes for the fixed-point alu
// depends on nothing
`timescale 1ns / 1ps
package fpa_pkg;
   localparam int FRACTION_BITS = 8;
   localparam int WORD_W = 32;
   localparam int NUM_W = WORD_W + FRACTION_BITS;  // dividend magnitude width
   localparam int MAG_W = 64;                      // product magnitude width
   localparam int NUM_CELLS = NUM_W;               // one quotient bit per cell

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_LT = 4'd4, OP_LE = 4'd5, OP_GT = 4'd6, OP_GE = 4'd7,
      OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
      OP_MIN = 4'd12, OP_MAX = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_OVERFLOW = 2'd1, ST_DIV_ZERO = 2'd2
   } status_type;

   // data handed from one cell to the next
   typedef struct packed {
      logic               valid;
      logic               is_div;   // final result comes from the quotient
      logic               neg;      // sign of quotient
      logic               dz;
      logic [NUM_W-1:0]   num;      // dividend bits, shifted out msb first
      logic [WORD_W-1:0]  den;
      logic [WORD_W:0]    rem;      // partial remainder
      logic [NUM_W-1:0]   quo;
      logic [WORD_W-1:0]  res;      // precomputed result for other ops
      logic               cond;
      status_type         status;
   } cell_type;
endpackage

@@ hdl/fpa_front.sv @@
// fpa_front: decodes an operation and computes every non-divide result
// depends on fpa_pkg
`timescale 1ns / 1ps
module fpa_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  fpa_pkg::op_type      op,
   input  logic signed [31:0]   a,
   input  logic signed [31:0]   b,
   output fpa_pkg::cell_type    cell_out
);
   import fpa_pkg::*;

   // product is registered before rounding
   logic signed [63:0] prod_ff, prod_in;
   cell_type           stg_ff, stg_in;
   cell_type           out_c;
   logic               is_mul_ff;
   logic [MAG_W-1:0]   pmag;
   logic [MAG_W-1:0]   prnd;

   function automatic logic [WORD_W-1:0] sat_mag(input logic neg, input logic [MAG_W-1:0] mag,
                                               output logic ovf);
      ovf = 1'b0;
      if (neg) begin
         if (mag > MAG_W'(64'h8000_0000)) begin
            ovf = 1'b1;
            return 32'h8000_0000;
         end
         return WORD_W'(~mag + 1'b1);
      end
      if (mag > MAG_W'(64'h7FFF_FFFF)) begin
         ovf = 1'b1;
         return 32'h7FFF_FFFF;
      end
      return mag[WORD_W-1:0];
   endfunction

   function automatic logic [MAG_W-1:0] mag64(input logic signed [MAG_W-1:0] v);
      return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
   endfunction

   always_comb begin
      logic signed [33:0] s;
      logic               ovf;
      logic [MAG_W-1:0]   ma;
      stg_in = '0;
      s = '0;
      ovf = 1'b0;
      ma = mag64(MAG_W'(a));
      stg_in.valid = in_valid;
      stg_in.status = ST_OK;
      prod_in = MAG_W'(a) * MAG_W'(b);
      unique case (op)
         OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
            unique case (op)
               OP_ADD:  s = 34'(a) + 34'(b);
               OP_SUB:  s = 34'(a) - 34'(b);
               OP_INC:  s = 34'(a) + 34'sd1;
               default: s = 34'(a) - 34'sd1;
            endcase
            stg_in.res = sat_mag(s[33], mag64(MAG_W'(s)), ovf);
         end
         OP_MUL: ;
         OP_DIV: begin
            stg_in.is_div = 1'b1;
            stg_in.neg = a[31] ^ b[31];
            stg_in.dz = (b == 0);
            stg_in.num = NUM_W'(ma) << FRACTION_BITS;
            stg_in.den = WORD_W'(mag64(MAG_W'(b)));
         end
         OP_LT: stg_in.cond = a < b;
         OP_LE: stg_in.cond = a <= b;
         OP_GT: stg_in.cond = a > b;
         OP_GE: stg_in.cond = a >= b;
         OP_EQ: stg_in.cond = a == b;
         OP_NE: stg_in.cond = a != b;
         OP_MIN: stg_in.res = (a < b) ? a : b;
         OP_MAX: stg_in.res = (a < b) ? b : a;
         OP_TO_INT: stg_in.res = sat_mag(a[31], ma >> FRACTION_BITS, ovf);
         default: stg_in.res = sat_mag(a[31], ma << FRACTION_BITS, ovf);
      endcase
      if (ovf) stg_in.status = ST_OVERFLOW;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_ff.valid <= 1'b0;
      end else if (advance) begin
         stg_ff <= stg_in;
         prod_ff <= prod_in;
         is_mul_ff <= (op == OP_MUL);
      end
   end

   // round the registered product, halves away from zero
   always_comb begin
      logic ovf;
      ovf = 1'b0;
      out_c = stg_ff;
      pmag = mag64(prod_ff);
      prnd = (pmag + MAG_W'((64'd1 << FRACTION_BITS) >> 1)) >> FRACTION_BITS;
      if (is_mul_ff) begin
         out_c.res = sat_mag(prod_ff[63], prnd, ovf);
         out_c.status = ovf ? ST_OVERFLOW : ST_OK;
      end
   end

   assign cell_out = out_c;
endmodule

@@ hdl/fpa_div_cell.sv @@
// fpa_div_cell: one restoring-division step, producing one quotient bit
// depends on fpa_pkg
`timescale 1ns / 1ps
module fpa_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  fpa_pkg::cell_type cell_in,
   output fpa_pkg::cell_type cell_out
);
   import fpa_pkg::*;

   cell_type cell_ff, cell_in_c;

   always_comb begin
      logic [WORD_W:0] trial;
      cell_in_c = cell_in;
      trial = {cell_in.rem[WORD_W-1:0], cell_in.num[NUM_W-1]};
      cell_in_c.num = cell_in.num << 1;
      if (cell_in.is_div && trial >= {1'b0, cell_in.den}) begin
         cell_in_c.rem = trial - {1'b0, cell_in.den};
         cell_in_c.quo = {cell_in.quo[NUM_W-2:0], 1'b1};
      end else begin
         cell_in_c.rem = trial;
         cell_in_c.quo = {cell_in.quo[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in_c;
      end
   end

   assign cell_out = cell_ff;
endmodule

@@ hdl/fixed_point_alu_unit.sv @@
// fixed_point_alu_unit: top level of the pipelined q24.8 fixed-point alu
// depends on fpa_pkg, fpa_front, fpa_div_cell
// throughput: one transfer per cycle; a chain of 40 division cells, one
// quotient bit each, followed by a rounding and output register
// a stall on a valid result freezes the whole chain in place
// reset: synchronous, active high, clears every valid bit in the chain
`timescale 1ns / 1ps
module fixed_point_alu_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [3:0]          req_type,
   input  logic signed [31:0]  req_operand_a,
   input  logic signed [31:0]  req_operand_b,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_result_word,
   output logic                rsp_cond_true,
   output logic [1:0]          rsp_status
);
   import fpa_pkg::*;

   cell_type chain [NUM_CELLS+1];
   logic     advance;
   cell_type last;
   logic [NUM_W:0] q_rnd;
   logic     out_valid_ff;
   logic [31:0] out_res_ff, out_res_in;
   logic     out_cond_ff;
   status_type out_st_ff, out_st_in;

   // chain moves whenever the output register is free or being drained
   assign advance = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   fpa_front u_front (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid), .op(op_type'(req_type)),
      .a(req_operand_a), .b(req_operand_b), .cell_out(chain[0])
   );

   // row of division cells, one quotient bit per cell
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      fpa_div_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .cell_in(chain[i]), .cell_out(chain[i+1])
      );
   end

   assign last = chain[NUM_CELLS];

   // round quotient: remainder at least half the divisor bumps it
   always_comb begin
      logic ovf;
      ovf = 1'b0;
      q_rnd = {1'b0, last.quo} +
              (NUM_W+1)'(({last.rem, 1'b0}) >= {2'b00, last.den} ? 1 : 0);
      out_res_in = last.res;
      out_st_in = last.status;
      if (last.is_div) begin
         if (last.dz) begin
            out_res_in = '0;
            out_st_in = ST_DIV_ZERO;
         end else begin
            out_st_in = ST_OK;
            if (last.neg) begin
               if (q_rnd > (NUM_W+1)'(33'h1_0000_0000 >> 1)) begin
                  ovf = 1'b1;
                  out_res_in = 32'h8000_0000;
               end else begin
                  out_res_in = 32'(~q_rnd + 1'b1);
               end
            end else if (q_rnd > (NUM_W+1)'(32'h7FFF_FFFF)) begin
               ovf = 1'b1;
               out_res_in = 32'h7FFF_FFFF;
            end else begin
               out_res_in = q_rnd[31:0];
            end
            if (ovf) out_st_in = ST_OVERFLOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= last.valid;
         out_res_ff <= out_res_in;
         out_cond_ff <= last.cond;
         out_st_ff <= out_st_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result_word = out_res_ff;
   assign rsp_cond_true = out_cond_ff;
   assign rsp_status = out_st_ff;

   // a held result stays put while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_word))
      else $error("result changed under stall");
   // input stall is exactly the output backpressure
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("spurious input stall");
   // a true compare reports no status and a zero result word
   a_cond: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cond_true |-> rsp_status == ST_OK && rsp_result_word == 0)
      else $error("compare with nonzero result");
endmodule

@@ tb/sv/testbench.sv @@
// testbench: self-checking bench for the pipelined fixed-point alu
// depends on fpa_pkg and fixed_point_alu_unit; predicts each result and checks it in order
`timescale 1ns / 1ps

// in-order store of predicted alu results with field-by-field compare
class alu_scoreboard;
   typedef struct {
      logic signed [31:0] word;
      logic               cond;
      logic [1:0]         status;
   } alu_result;

   alu_result pending[$];
   int        errors = 0;
   int        checked = 0;

   // saturate a signed magnitude to a 32-bit word
   function automatic logic [31:0] clamp_mag(bit neg, logic [63:0] mag,
                                             ref logic [1:0] st);
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            st = fpa_pkg::ST_OVERFLOW;
            return 32'h8000_0000;
         end
         return 32'(-mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         st = fpa_pkg::ST_OVERFLOW;
         return 32'h7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   function automatic logic [31:0] clamp_wide(longint v, ref logic [1:0] st);
      if (v < 0) return clamp_mag(1'b1, 64'(-v), st);
      return clamp_mag(1'b0, 64'(v), st);
   endfunction

   // note an accepted operation and compute what the alu must return
   function void note_operation(fpa_pkg::op_type op, logic signed [31:0] a,
                                logic signed [31:0] b);
      alu_result   r;
      longint      sa, sb, p;
      logic [63:0] ma, mb, m, q, rem;
      logic [1:0]  st;
      int          fb;
      fb = fpa_pkg::FRACTION_BITS;
      sa = a;
      sb = b;
      ma = sa < 0 ? 64'(-sa) : 64'(sa);
      mb = sb < 0 ? 64'(-sb) : 64'(sb);
      st = fpa_pkg::ST_OK;
      r.word = '0;
      r.cond = 1'b0;
      case (op)
         fpa_pkg::OP_ADD: r.word = clamp_wide(sa + sb, st);
         fpa_pkg::OP_SUB: r.word = clamp_wide(sa - sb, st);
         fpa_pkg::OP_MUL: begin
            p = sa * sb;
            m = ((p < 0 ? 64'(-p) : 64'(p)) + ((64'd1 << fb) >> 1)) >> fb;
            r.word = clamp_mag(p < 0, m, st);
         end
         fpa_pkg::OP_DIV: begin
            if (sb == 0) begin
               st = fpa_pkg::ST_DIV_ZERO;
            end else begin
               q = (ma << fb) / mb;
               rem = (ma << fb) % mb;
               if (2 * rem >= mb) q = q + 1;
               r.word = clamp_mag((sa < 0) != (sb < 0), q, st);
            end
         end
         fpa_pkg::OP_LT: r.cond = sa < sb;
         fpa_pkg::OP_LE: r.cond = sa <= sb;
         fpa_pkg::OP_GT: r.cond = sa > sb;
         fpa_pkg::OP_GE: r.cond = sa >= sb;
         fpa_pkg::OP_EQ: r.cond = sa == sb;
         fpa_pkg::OP_NE: r.cond = sa != sb;
         fpa_pkg::OP_INC: r.word = clamp_wide(sa + 1, st);
         fpa_pkg::OP_DEC: r.word = clamp_wide(sa - 1, st);
         fpa_pkg::OP_MIN: r.word = sa < sb ? a : b;
         fpa_pkg::OP_MAX: r.word = sa < sb ? b : a;
         fpa_pkg::OP_TO_INT: r.word = clamp_mag(sa < 0, ma >> fb, st);
         default: r.word = clamp_mag(sa < 0, ma << fb, st);
      endcase
      r.status = st;
      pending.push_back(r);
   endfunction

   // compare one result transfer with the oldest prediction
   function void check_result(logic signed [31:0] word, logic cond,
                              logic [1:0] status);
      alu_result e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result word %h cond %b status %0d",
                  $time, word, cond, status);
         errors++;
         return;
      end
      e = pending.pop_front();
      checked++;
      if (word !== e.word) begin
         $display("%0t: result word expected %h actual %h", $time, e.word, word);
         errors++;
      end
      if (cond !== e.cond) begin
         $display("%0t: cond expected %b actual %b", $time, e.cond, cond);
         errors++;
      end
      if (status !== e.status) begin
         $display("%0t: status expected %0d actual %0d", $time, e.status, status);
         errors++;
      end
   endfunction
endclass

module testbench;
   import fpa_pkg::*;

   localparam int RANDOM_OPS = 1600;
   localparam int LATENCY = 1 + NUM_CELLS;
   localparam int WATCHDOG_LIMIT = 2000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [3:0]         req_type;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_result_word;
   logic               rsp_cond_true;
   logic [1:0]         rsp_status;

   alu_scoreboard board;
   bit  idle_enable = 1'b1;    // random gaps on both sides
   bit  long_hold = 1'b0;      // request for a long receiver hold-off
   bit  timed_out = 1'b0;
   int  quiet_cycles = 0;

   fixed_point_alu_unit DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // transfers are observed on the rising edge, before the new drive lands
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_result_word, rsp_cond_true, rsp_status);
   end

   // watchdog: cycles in which no transfer happens on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
            long_hold = 1'b0;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // offer one operation and hold it until it transfers
   task automatic send_op(op_type op, logic signed [31:0] a, logic signed [31:0] b);
      int n;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_operation(op, a, b);
   endtask

   function automatic logic signed [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
         1: return 32'sh8000_0000 + $urandom_range(0, 3);
         2: return $signed(32'($urandom_range(0, 4096))) - 2048;
         3: return $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
         4: return 32'($urandom_range(0, 2)) - 1;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic signed [31:0] a, b;
      op_type             op;
      int                 i, k;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = OP_ADD;
      req_operand_a = '0;
      req_operand_b = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, overflow, divide by zero, rounding ties
      send_op(OP_ADD, 32'sh7FFF_FFFF, 32'sd1);
      send_op(OP_SUB, 32'sh8000_0000, 32'sd1);
      send_op(OP_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_op(OP_MUL, 32'sh8000_0000, 32'sh8000_0000);
      send_op(OP_MUL, 32'sd384, 32'sd1);          // half-lsb tie, rounds up
      send_op(OP_MUL, -32'sd384, 32'sd1);         // negative tie, away from zero
      send_op(OP_DIV, 32'sd100, 32'sd0);
      send_op(OP_DIV, 32'sh7FFF_FFFF, 32'sd1);
      send_op(OP_DIV, 32'sd1, 32'sd512);          // exact half quotient
      send_op(OP_DIV, 32'sh8000_0000, -32'sd1);
      send_op(OP_LT, 32'sd5, 32'sd5);
      send_op(OP_LE, 32'sd5, 32'sd5);
      send_op(OP_GT, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_op(OP_GE, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_op(OP_EQ, -32'sd1, -32'sd1);
      send_op(OP_NE, 32'sd0, 32'sd1);
      send_op(OP_INC, 32'sh7FFF_FFFF, 32'sd0);
      send_op(OP_DEC, 32'sh8000_0000, -32'sd1);
      send_op(OP_MIN, 32'sd7, 32'sd7);
      send_op(OP_MAX, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_op(OP_TO_INT, -32'sd257, 32'sd0);      // truncates toward zero
      send_op(OP_TO_INT, 32'sh8000_0000, 32'sd0);
      send_op(OP_FROM_INT, 32'sh0080_0000, 32'sd0);
      send_op(OP_FROM_INT, 32'sh8000_0000, 32'sd0);
      send_op(OP_FROM_INT, -32'sd3, 32'sd0);

      // sender pause until the pipeline has drained
      req_valid <= 1'b0;
      while (board.pending.size() != 0 && !timed_out) @(posedge clock);

      for (i = 0; i < RANDOM_OPS; i++) begin
         if (i == 300) long_hold = 1'b1;   // receiver holds, pipe fills, input stalls
         if (i == RANDOM_OPS - 200) idle_enable = 1'b0;
         op = op_type'($urandom_range(0, 15));
         a = pick_operand();
         b = pick_operand();
         k = $urandom_range(0, 9);
         if (op == OP_DIV && k == 0) b = '0;
         if (k == 1) b = a;
         send_op(op, a, b);
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0 && !timed_out) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("tb: %0d results checked over all 16 operations, with saturation,",
               board.checked);
      $display("tb: divide by zero, rounding ties, stalls and a full-pipeline hold-off");
      if (board.errors == 0 && board.pending.size() == 0 && !timed_out) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
